FILE: hdl/gcc_pkg.sv
// Shared types and constants for the genotype class counter.
package gcc_pkg;

	localparam int ROW_W   = 20;
	localparam int WORD_W  = 16;
	localparam int CODE_W  = 8;
	localparam int COUNT_W = 17;

	localparam int MAX_COLUMNS = 65536;
	localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
	localparam int LIMIT_INT   = (MAX_COLUMNS > COUNT_MAX) ? COUNT_MAX : MAX_COLUMNS;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);

	localparam logic [CODE_W-1:0] CODE_UNKNOWN = 8'hFF;

	// class indexes into the counter bank
	localparam logic [1:0] CLS_UNK = 2'd0;
	localparam logic [1:0] CLS_AA  = 2'd1;
	localparam logic [1:0] CLS_AB  = 2'd2;
	localparam logic [1:0] CLS_BB  = 2'd3;

	// decoded genotype code from one lane
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              unk;
		logic              hom;
		logic              het;
	} lane_t;

	// one row result
	typedef struct packed {
		logic [COUNT_W-1:0] unknown_count;
		logic [COUNT_W-1:0] hom_a_count;
		logic [COUNT_W-1:0] het_count;
		logic [COUNT_W-1:0] hom_b_count;
		logic [CODE_W-1:0]  hom_a_code;
		logic [CODE_W-1:0]  het_code;
		logic [CODE_W-1:0]  hom_b_code;
		logic               class_error;
	} result_t;

endpackage

FILE: hdl/genotype_class_counter.sv
// Top level of the genotype class counter: handshakes, lanes, merge and result queue.
//
// Takes one packed word (two genotype codes) per clock cycle, back to back, with no gaps
// between rows. Two decode lanes classify the high and low code in parallel and a merge
// stage applies them in column order to the row's class slots and four saturating counters.
// The word marked last_word yields one result, registered into the output register, or into
// the skid entry while that register still waits; other words yield none. A two-entry output
// queue (register plus skid) lets input keep flowing while a result waits; input stalls only
// when both entries are full. odd_column_count must be written over the cfg channel while
// the block is idle; the block does not enforce this. cfg_ready is always high. A row whose
// index repeats the row just completed is not recounted and its held result is sent again.
module genotype_class_counter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gcc_pkg::ROW_W-1:0]   row_index,
	input  logic [gcc_pkg::WORD_W-1:0]  packed_word,
	input  logic                        last_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gcc_pkg::COUNT_W-1:0] unknown_count,
	output logic [gcc_pkg::COUNT_W-1:0] hom_a_count,
	output logic [gcc_pkg::COUNT_W-1:0] het_count,
	output logic [gcc_pkg::COUNT_W-1:0] hom_b_count,
	output logic [gcc_pkg::CODE_W-1:0]  hom_a_code,
	output logic [gcc_pkg::CODE_W-1:0]  het_code,
	output logic [gcc_pkg::CODE_W-1:0]  hom_b_code,
	output logic                        class_error
);

	logic             odd_q;
	logic             accept;
	gcc_pkg::lane_t   lane_hi;
	gcc_pkg::lane_t   lane_lo;
	logic             res_valid;
	gcc_pkg::result_t res;
	gcc_pkg::result_t out_q;
	gcc_pkg::result_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             drain;

	// hold the column-parity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q <= 1'b0;
		end else if (cfg_valid) begin
			odd_q <= cfg_data;
		end
	end

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	// decode both codes of the word side by side
	gcc_lane u_lane_hi (
		.code (packed_word[15:8]),
		.lane (lane_hi)
	);

	gcc_lane u_lane_lo (
		.code (packed_word[7:0]),
		.lane (lane_lo)
	);

	gcc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.row_index (row_index),
		.last_word (last_word),
		.odd_cols  (odd_q),
		.lane_hi   (lane_hi),
		.lane_lo   (lane_lo),
		.res_valid (res_valid),
		.res       (res)
	);

	assign drain = out_valid_q && out_ready;

	// advance results through the output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (drain) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !drain) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (drain) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !drain) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign unknown_count = out_q.unknown_count;
	assign hom_a_count   = out_q.hom_a_count;
	assign het_count     = out_q.het_count;
	assign hom_b_count   = out_q.hom_b_count;
	assign hom_a_code    = out_q.hom_a_code;
	assign het_code      = out_q.het_code;
	assign hom_b_code    = out_q.hom_b_code;
	assign class_error   = out_q.class_error;

endmodule

FILE: hdl/gcc_lane.sv
// Decode lane: classifies one 8-bit genotype code.
module gcc_lane (
	input  logic [gcc_pkg::CODE_W-1:0] code,
	output gcc_pkg::lane_t             lane
);

	// unknown first, then nibble compare for homozygous
	always_comb begin
		lane.code = code;
		lane.unk  = (code == gcc_pkg::CODE_UNKNOWN);
		lane.hom  = !lane.unk && (code[3:0] == code[7:4]);
		lane.het  = !lane.unk && !lane.hom;
	end

endmodule

FILE: hdl/gcc_merge.sv
// Merge stage: applies both lane codes in column order to the row state.
module gcc_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [gcc_pkg::ROW_W-1:0]  row_index,
	input  logic                       last_word,
	input  logic                       odd_cols,
	input  gcc_pkg::lane_t             lane_hi,
	input  gcc_pkg::lane_t             lane_lo,
	output logic                       res_valid,
	output gcc_pkg::result_t           res
);

	typedef struct packed {
		logic [gcc_pkg::CODE_W-1:0] aa_code;
		logic [gcc_pkg::CODE_W-1:0] ab_code;
		logic [gcc_pkg::CODE_W-1:0] bb_code;
		logic                       aa_v;
		logic                       ab_v;
		logic                       bb_v;
		logic                       err;
	} slot_t;

	typedef struct packed {
		slot_t      st;
		logic [3:0] inc;
	} step_t;

	logic [gcc_pkg::ROW_W-1:0]   sel_row_q;
	logic                        row_known_q;
	logic                        mid_row_q;
	logic                        skip_q;
	slot_t                       slot_q;
	logic [gcc_pkg::COUNT_W-1:0] cnt_q [4];

	logic                        first;
	logic                        skip;
	logic                        clr;
	logic                        lo_en;
	slot_t                       slot_start;
	step_t                       step_hi;
	step_t                       step_lo;
	logic [gcc_pkg::COUNT_W-1:0] cnt_start [4];
	logic [gcc_pkg::COUNT_W-1:0] cnt_next [4];

	// classify one code against the slots, returning new slots and the class hit
	function automatic step_t apply(input slot_t s, input gcc_pkg::lane_t l,
		input logic en);
		step_t r;
		r.st  = s;
		r.inc = 4'b0000;
		if (en) begin
			if (l.unk) begin
				r.inc[gcc_pkg::CLS_UNK] = 1'b1;
			end else if (l.hom) begin
				if (!s.aa_v) begin
					r.st.aa_code = l.code;
					r.st.aa_v    = 1'b1;
					r.inc[gcc_pkg::CLS_AA] = 1'b1;
				end else if (s.aa_code == l.code) begin
					r.inc[gcc_pkg::CLS_AA] = 1'b1;
				end else if (!s.bb_v) begin
					r.st.bb_code = l.code;
					r.st.bb_v    = 1'b1;
					r.inc[gcc_pkg::CLS_BB] = 1'b1;
				end else if (s.bb_code == l.code) begin
					r.inc[gcc_pkg::CLS_BB] = 1'b1;
				end else begin
					r.st.err = 1'b1;
				end
			end else begin
				if (!s.ab_v) begin
					r.st.ab_code = l.code;
					r.st.ab_v    = 1'b1;
				end else if (s.ab_code != l.code) begin
					r.st.err = 1'b1;
				end
				r.inc[gcc_pkg::CLS_AB] = 1'b1;
			end
		end
		return r;
	endfunction

	// row start: skip a repeat of the last row, else clear the row state
	always_comb begin
		first = !mid_row_q;
		skip  = first ? (row_known_q && (row_index == sel_row_q)) : skip_q;
		clr   = first && !skip;
		lo_en = !(last_word && odd_cols);
		slot_start = clr ? '0 : slot_q;
		for (int i = 0; i < 4; i++) begin
			cnt_start[i] = clr ? '0 : cnt_q[i];
		end
	end

	// high byte first, then low byte on the updated slots
	always_comb begin
		step_hi = apply(slot_start, lane_hi, !skip);
		step_lo = apply(step_hi.st, lane_lo, !skip && lo_en);
	end

	// saturating count update, at most two per word
	always_comb begin
		logic [gcc_pkg::COUNT_W:0] sum;
		sum = '0;
		for (int i = 0; i < 4; i++) begin
			sum = {1'b0, cnt_start[i]}
				+ (gcc_pkg::COUNT_W+1)'(step_hi.inc[i])
				+ (gcc_pkg::COUNT_W+1)'(step_lo.inc[i]);
			if (sum > {1'b0, gcc_pkg::COUNT_LIMIT}) begin
				cnt_next[i] = gcc_pkg::COUNT_LIMIT;
			end else begin
				cnt_next[i] = sum[gcc_pkg::COUNT_W-1:0];
			end
		end
	end

	// hold row control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_row_q   <= '0;
			row_known_q <= 1'b0;
			mid_row_q   <= 1'b0;
			skip_q      <= 1'b0;
			slot_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept) begin
			mid_row_q <= !last_word;
			skip_q    <= skip;
			if (clr) begin
				sel_row_q   <= row_index;
				row_known_q <= 1'b1;
			end
			slot_q <= step_lo.st;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= cnt_next[i];
			end
		end
	end

	// result of the word that closes a row
	always_comb begin
		res_valid         = accept && last_word;
		res.unknown_count = cnt_next[gcc_pkg::CLS_UNK];
		res.hom_a_count   = cnt_next[gcc_pkg::CLS_AA];
		res.het_count     = cnt_next[gcc_pkg::CLS_AB];
		res.hom_b_count   = cnt_next[gcc_pkg::CLS_BB];
		res.hom_a_code    = step_lo.st.aa_code;
		res.het_code      = step_lo.st.ab_code;
		res.hom_b_code    = step_lo.st.bb_code;
		res.class_error   = step_lo.st.err;
	end

endmodule

FILE: tb/sv/genotype_class_counter_tb.sv
// Self-checking testbench for the genotype class counter: directed rows, then random rows.
`timescale 1ns / 1ps

module genotype_class_counter_tb;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_WORDS = 650;

	// one row of the opening table
	typedef struct packed {
		logic                         odd;
		logic [gcc_pkg::ROW_W-1:0]    idx;
		logic [gcc_pkg::WORD_W-1:0]   word;
		logic                         last;
		logic                         typed;
		gcc_pkg::result_t             want;
	} plan_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic                         cfg_data = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [gcc_pkg::ROW_W-1:0]    row_index = '0;
	logic [gcc_pkg::WORD_W-1:0]   packed_word = '0;
	logic                         last_word = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [gcc_pkg::COUNT_W-1:0]  unknown_count;
	logic [gcc_pkg::COUNT_W-1:0]  hom_a_count;
	logic [gcc_pkg::COUNT_W-1:0]  het_count;
	logic [gcc_pkg::COUNT_W-1:0]  hom_b_count;
	logic [gcc_pkg::CODE_W-1:0]   hom_a_code;
	logic [gcc_pkg::CODE_W-1:0]   het_code;
	logic [gcc_pkg::CODE_W-1:0]   hom_b_code;
	logic                         class_error;

	// predictor state
	logic [gcc_pkg::ROW_W-1:0]    sel_row = '0;
	bit                           have_row = 1'b0;
	bit                           row_open = 1'b0;
	bit                           row_skip = 1'b0;
	bit                           odd_cols = 1'b0;
	logic [gcc_pkg::CODE_W-1:0]   aa_reg = '0;
	logic [gcc_pkg::CODE_W-1:0]   het_reg = '0;
	logic [gcc_pkg::CODE_W-1:0]   bb_reg = '0;
	bit                           aa_set = 1'b0;
	bit                           het_set = 1'b0;
	bit                           bb_set = 1'b0;
	bit                           err_flag = 1'b0;
	logic [gcc_pkg::COUNT_W-1:0]  tally [4] = '{default: '0};

	gcc_pkg::result_t             expected_tallies [$];
	plan_t                        opening_steps [$];

	// run bookkeeping
	int                  fail_count = 0;
	int                  results_checked = 0;
	int                  error_results = 0;
	int                  repeat_rows = 0;
	int                  rows_closed = 0;
	int                  words_sent = 0;
	int                  rand_words = 0;
	int                  cycle_count = 0;
	int                  hold_left = 0;
	bit                  tx_calm = 1'b0;
	bit                  rx_calm = 1'b0;

	genotype_class_counter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.row_index     (row_index),
		.packed_word   (packed_word),
		.last_word     (last_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.unknown_count (unknown_count),
		.hom_a_count   (hom_a_count),
		.het_count     (het_count),
		.hom_b_count   (hom_b_count),
		.hom_a_code    (hom_a_code),
		.het_code      (het_code),
		.hom_b_code    (hom_b_code),
		.class_error   (class_error)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("genotype_class_counter verification failed");
			$finish;
		end
	end

	function automatic gcc_pkg::result_t row_tally(input int unk, input int aa, input int het,
			input int bb, input logic [gcc_pkg::CODE_W-1:0] ac,
			input logic [gcc_pkg::CODE_W-1:0] hc, input logic [gcc_pkg::CODE_W-1:0] bc,
			input int err);
		return {gcc_pkg::COUNT_W'(unk), gcc_pkg::COUNT_W'(aa), gcc_pkg::COUNT_W'(het),
			gcc_pkg::COUNT_W'(bb), ac, hc, bc, (err != 0)};
	endfunction

	function automatic string show_tally(input gcc_pkg::result_t t);
		return $sformatf("unk=%0d aa=%0d het=%0d bb=%0d codes aa=%h het=%h bb=%h err=%0b",
			t.unknown_count, t.hom_a_count, t.het_count, t.hom_b_count,
			t.hom_a_code, t.het_code, t.hom_b_code, t.class_error);
	endfunction

	// saturating count of one class
	function automatic void bump_class(input logic [1:0] cls);
		if (tally[cls] < gcc_pkg::COUNT_LIMIT)
			tally[cls] = tally[cls] + 1'b1;
	endfunction

	// place one code into its class slot
	function automatic void classify_code(input logic [gcc_pkg::CODE_W-1:0] code);
		if (code == gcc_pkg::CODE_UNKNOWN) begin
			bump_class(gcc_pkg::CLS_UNK);
		end else if (code[3:0] == code[7:4]) begin
			if (!aa_set) begin
				aa_reg = code;
				aa_set = 1'b1;
				bump_class(gcc_pkg::CLS_AA);
			end else if (aa_reg == code) begin
				bump_class(gcc_pkg::CLS_AA);
			end else if (!bb_set) begin
				bb_reg = code;
				bb_set = 1'b1;
				bump_class(gcc_pkg::CLS_BB);
			end else if (bb_reg == code) begin
				bump_class(gcc_pkg::CLS_BB);
			end else begin
				err_flag = 1'b1;
			end
		end else begin
			if (!het_set) begin
				het_reg = code;
				het_set = 1'b1;
			end else if (het_reg != code) begin
				err_flag = 1'b1;
			end
			bump_class(gcc_pkg::CLS_AB);
		end
	endfunction

	// advance the predictor by one word; a last word yields a row result
	task automatic tally_word(input logic [gcc_pkg::ROW_W-1:0] idx,
			input logic [gcc_pkg::WORD_W-1:0] word, input logic last, output bit done,
			output gcc_pkg::result_t res);
		if (!row_open) begin
			if (have_row && idx == sel_row) begin
				row_skip = 1'b1;
				repeat_rows++;
			end else begin
				row_skip = 1'b0;
				aa_reg = '0;
				het_reg = '0;
				bb_reg = '0;
				aa_set = 1'b0;
				het_set = 1'b0;
				bb_set = 1'b0;
				err_flag = 1'b0;
				for (int c = 0; c < 4; c++)
					tally[c] = '0;
				sel_row = idx;
				have_row = 1'b1;
			end
		end
		if (!row_skip) begin
			classify_code(word[15:8]);
			if (!(last && odd_cols))
				classify_code(word[7:0]);
		end
		row_open = !last;
		done = last;
		if (last)
			rows_closed++;
		res = {tally[gcc_pkg::CLS_UNK], tally[gcc_pkg::CLS_AA], tally[gcc_pkg::CLS_AB],
			tally[gcc_pkg::CLS_BB], aa_reg, het_reg, bb_reg, err_flag};
	endtask

	// compare one row result with the oldest expectation
	task automatic check_tally(input gcc_pkg::result_t got);
		gcc_pkg::result_t want;
		string bad;
		bad = "";
		if (expected_tallies.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected row result: %s", show_tally(got));
		end else begin
			want = expected_tallies.pop_front();
			if (got.unknown_count !== want.unknown_count) bad = {bad, " unknown_count"};
			if (got.hom_a_count !== want.hom_a_count) bad = {bad, " hom_a_count"};
			if (got.het_count !== want.het_count) bad = {bad, " het_count"};
			if (got.hom_b_count !== want.hom_b_count) bad = {bad, " hom_b_count"};
			if (got.hom_a_code !== want.hom_a_code) bad = {bad, " hom_a_code"};
			if (got.het_code !== want.het_code) bad = {bad, " het_code"};
			if (got.hom_b_code !== want.hom_b_code) bad = {bad, " hom_b_code"};
			if (got.class_error !== want.class_error) bad = {bad, " class_error"};
			if (bad != "") begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("row result %0d mismatch in%s", results_checked, bad);
					$display("  expected %s", show_tally(want));
					$display("  actual   %s", show_tally(got));
				end
			end
			if (want.class_error)
				error_results++;
			results_checked++;
		end
	endtask

	// take results, holding off for a random gap after each result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				check_tally({unknown_count, hom_a_count, het_count, hom_b_count,
					hom_a_code, het_code, hom_b_code, class_error});
				hold_left = rx_calm ? 0 : $urandom_range(0, 13);
			end else if (out_valid && hold_left > 0) begin
				hold_left--;
			end
			out_ready <= (hold_left == 0);
		end
	end

	// send one word after a random gap and predict its result on transfer
	task automatic push_word(input logic [gcc_pkg::ROW_W-1:0] idx,
			input logic [gcc_pkg::WORD_W-1:0] word, input logic last, input bit typed,
			input gcc_pkg::result_t want);
		int gap;
		bit done;
		gcc_pkg::result_t res;
		gap = tx_calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_index <= idx;
		packed_word <= word;
		last_word <= last;
		do @(posedge clk); while (!in_ready);
		tally_word(idx, word, last, done, res);
		if (done)
			expected_tallies.push_back(typed ? want : res);
		words_sent++;
	endtask

	// drop valid and hold until every expected result is in
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_tallies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write odd_column_count while the block is idle
	task automatic write_odd(input bit v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		odd_cols = v;
	endtask

	task automatic plan(input int odd, input logic [gcc_pkg::ROW_W-1:0] idx,
			input logic [gcc_pkg::WORD_W-1:0] word, input int last, input int typed,
			input gcc_pkg::result_t want);
		plan_t p;
		p.odd = (odd != 0);
		p.idx = idx;
		p.word = word;
		p.last = (last != 0);
		p.typed = (typed != 0);
		p.want = want;
		opening_steps.push_back(p);
	endtask

	// one well-formed row drawn from a small per-row palette of codes
	task automatic send_random_row();
		logic [gcc_pkg::ROW_W-1:0]  idx;
		logic [gcc_pkg::CODE_W-1:0] hom_pick [3];
		logic [gcc_pkg::CODE_W-1:0] het_pick [2];
		logic [gcc_pkg::CODE_W-1:0] code;
		logic [gcc_pkg::WORD_W-1:0] word;
		logic [3:0]                 nib;
		int                         len;
		int                         roll;
		roll = $urandom_range(0, 9);
		if (roll < 2)
			idx = sel_row;
		else if (roll == 2)
			idx = '0;
		else if (roll == 3)
			idx = '1;
		else
			idx = gcc_pkg::ROW_W'($urandom);
		for (int k = 0; k < 3; k++) begin
			nib = 4'($urandom_range(0, 14));
			hom_pick[k] = {nib, nib};
		end
		for (int k = 0; k < 2; k++) begin
			nib = 4'($urandom_range(0, 15));
			het_pick[k] = {nib, nib + 4'($urandom_range(1, 15))};
		end
		word = '0;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
		for (int w = 0; w < len; w++) begin
			for (int lane = 0; lane < 2; lane++) begin
				roll = $urandom_range(0, 99);
				if (roll < 15)
					code = gcc_pkg::CODE_UNKNOWN;
				else if (roll < 55)
					code = hom_pick[roll & 1];
				else if (roll < 60)
					code = hom_pick[2];
				else if (roll < 88)
					code = het_pick[0];
				else if (roll < 92)
					code = het_pick[1];
				else
					code = gcc_pkg::CODE_W'($urandom);
				word = {word[7:0], code};
			end
			push_word((w == 0) ? idx : gcc_pkg::ROW_W'($urandom), word, w == len - 1,
				1'b0, '0);
			rand_words++;
		end
	endtask

	initial begin
		int ph;
		// row after reset, repeats, code zero, stray classes, odd column rows
		plan(0, 20'd0, 16'hFFFF, 1, 1, row_tally(2, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0));
		plan(0, 20'd0, 16'h0000, 1, 1, row_tally(2, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0));
		plan(0, 20'd1, 16'h0000, 1, 1, row_tally(0, 2, 0, 0, 8'h00, 8'h00, 8'h00, 0));
		plan(0, 20'd2, 16'h0011, 0, 0, '0);
		plan(0, 20'd5, 16'h2233, 0, 0, '0);
		plan(0, 20'd7, 16'h1201, 1, 1, row_tally(0, 1, 2, 1, 8'h00, 8'h12, 8'h11, 1));
		plan(0, 20'd2, 16'hFFFF, 1, 1, row_tally(0, 1, 2, 1, 8'h00, 8'h12, 8'h11, 1));
		plan(0, 20'hFFFFF, 16'h8877, 0, 0, '0);
		plan(0, 20'd0, 16'hA55A, 0, 0, '0);
		plan(0, 20'd0, 16'h7788, 1, 0, '0);
		plan(0, 20'd3, 16'hEEEE, 0, 0, '0);
		plan(0, 20'd3, 16'hEFFF, 1, 1, row_tally(1, 2, 1, 0, 8'hEE, 8'hEF, 8'h00, 0));
		plan(1, 20'd4, 16'h33FF, 1, 1, row_tally(0, 1, 0, 0, 8'h33, 8'h00, 8'h00, 0));
		plan(1, 20'd5, 16'hFFFF, 0, 0, '0);
		plan(1, 20'd5, 16'h4455, 1, 1, row_tally(2, 1, 0, 0, 8'h44, 8'h00, 8'h00, 0));
		plan(1, 20'd5, 16'h0000, 1, 1, row_tally(2, 1, 0, 0, 8'h44, 8'h00, 8'h00, 0));
		plan(1, 20'd6, 16'h0FF0, 1, 1, row_tally(0, 0, 1, 0, 8'h00, 8'h0F, 8'h00, 0));
		plan(1, 20'd8, 16'h1234, 0, 0, '0);
		plan(1, 20'd8, 16'hFF56, 1, 1, row_tally(1, 0, 2, 0, 8'h00, 8'h12, 8'h00, 1));
		plan(0, 20'd9, 16'h9999, 0, 0, '0);
		plan(0, 20'd9, 16'h9999, 1, 0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the opening table, rewriting the register where a row asks
		foreach (opening_steps[i]) begin
			if (opening_steps[i].odd != odd_cols)
				write_odd(opening_steps[i].odd);
			push_word(opening_steps[i].idx, opening_steps[i].word, opening_steps[i].last,
				opening_steps[i].typed, opening_steps[i].want);
		end

		// random rows in phases that alternate the register setting
		ph = 1;
		while (rand_words < RANDOM_WORDS) begin
			write_odd(ph % 2 == 1);
			for (int r = 0; r < 20 && rand_words < RANDOM_WORDS; r++) begin
				if ($urandom_range(0, 7) == 0) begin
					tx_calm = ($urandom_range(0, 3) == 0);
					rx_calm = ($urandom_range(0, 3) == 0);
				end
				if ($urandom_range(0, 14) == 0)
					wait_drained();
				send_random_row();
			end
			ph++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("sent %0d words in %0d rows (%0d repeated rows re-sent), checked %0d results",
			words_sent, rows_closed, repeat_rows, results_checked);
		$display("%0d results carried a class error; rows ran under both odd column settings",
			error_results);
		if (fail_count == 0 && expected_tallies.size() == 0) begin
			$display("genotype_class_counter verification clean");
		end else begin
			$display("genotype_class_counter verification failed");
		end
		$finish;
	end

endmodule
